/* hdl/one_to_one_assignment_table_core_macros.svh */
// Assertion macros for the one-to-one assignment table checker.
// Each macro expands to one labeled concurrent assertion on clk, disabled during arst_n.
`ifndef ONE_TO_ONE_ASSIGNMENT_TABLE_CORE_MACROS_SVH
`define ONE_TO_ONE_ASSIGNMENT_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ott_pkg.sv */
// Shared types and constants of the one-to-one assignment table.
// Used by the controller, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ott_pkg;

	localparam int unsigned MAX_SIDE  = 1024;
	localparam int unsigned IDX_W     = $clog2(MAX_SIDE);
	localparam int unsigned SIDE_W    = IDX_W + 1;
	localparam int unsigned ENT_W     = SIDE_W;
	localparam int unsigned VAL_W     = 12;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_SIDE - 1);
	// A map entry holds the partner index, or all ones (-1) when unassigned.
	localparam logic [ENT_W-1:0]  ENTRY_NONE = '1;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_COUNT     = 3'd1,
		CMD_TRANSPOSE = 3'd2,
		CMD_CLEAR     = 3'd3,
		CMD_READ_ROW  = 3'd4,
		CMD_READ_COL  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_DROP,
		ST_ADD_SET,
		ST_COUNT,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [IDX_W-1:0]  row_index;
		logic [IDX_W-1:0]  col_index;
		logic [SIDE_W-1:0] row_end;
		logic [SIDE_W-1:0] col_end;
	} request_t;

	typedef struct packed {
		logic                    status;
		logic signed [VAL_W-1:0] value;
		logic [SIDE_W-1:0]       pair_count;
	} result_t;

	typedef struct packed {
		logic [SIDE_W-1:0] rows;
		logic [SIDE_W-1:0] cols;
	} sizes_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ENT_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

/* hdl/ott_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ott_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/ott_ctrl.sv */
// Command sequencer of the assignment table: read-modify-write of the two maps,
// block walk, clearing pass, pair count and result register. Uses ott_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ott_ctrl
	import ott_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire request_t         request,
	input  wire sizes_t           sizes,
	input  wire logic [ENT_W-1:0] rd_a,
	input  wire logic [ENT_W-1:0] rd_b,
	output logic                  busy,
	output logic                  done,
	output result_t               result,
	output ram_req_t              ram_a,
	output ram_req_t              ram_b
);

	state_t            state_q, state_d;
	request_t          req_q;
	logic              load_req;
	logic              swap_q, swap_d;
	logic              report_q, report_d;
	logic [SIDE_W-1:0] pairs_q, pairs_d;
	logic [SIDE_W-1:0] cnt_q, cnt_d;
	logic [SIDE_W-1:0] stop_q, stop_d;
	logic [SIDE_W-1:0] acc_q, acc_d;
	logic              done_q, done_d;
	result_t           result_q, result_d;

	ram_req_t          r_req, c_req;
	logic [SIDE_W-1:0] nrows, ncols, stop_sel, acc_sum;
	logic [ENT_W-1:0]  rd_r, rd_c, entry;
	logic              row_ok, col_ok, pr_valid, pc_valid, hit;
	logic [1:0]        drops;

	// The row map is the row_to_col memory (a) unless the roles are swapped.
	assign nrows = swap_q ? sizes.cols : sizes.rows;
	assign ncols = swap_q ? sizes.rows : sizes.cols;
	assign rd_r  = swap_q ? rd_b : rd_a;
	assign rd_c  = swap_q ? rd_a : rd_b;
	assign ram_a = swap_q ? c_req : r_req;
	assign ram_b = swap_q ? r_req : c_req;

	assign row_ok   = {1'b0, request.row_index} < nrows;
	assign col_ok   = {1'b0, request.col_index} < ncols;
	assign stop_sel = (request.row_end < nrows) ? request.row_end : nrows;

	always_comb begin
		state_d  = state_q;
		swap_d   = swap_q;
		report_d = report_q;
		pairs_d  = pairs_q;
		cnt_d    = cnt_q;
		stop_d   = stop_q;
		acc_d    = acc_q;
		done_d   = 1'b0;
		result_d = result_q;
		load_req = 1'b0;
		r_req    = '0;
		c_req    = '0;
		pr_valid = ~rd_r[ENT_W-1];
		pc_valid = ~rd_c[ENT_W-1];
		drops    = 2'd0;
		entry    = rd_r;
		hit      = 1'b0;
		acc_sum  = acc_q;

		unique case (state_q)
			ST_CLEAR: begin
				r_req.we    = 1'b1;
				r_req.waddr = cnt_q[IDX_W-1:0];
				r_req.wdata = ENTRY_NONE;
				c_req.we    = 1'b1;
				c_req.waddr = cnt_q[IDX_W-1:0];
				c_req.wdata = ENTRY_NONE;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q[IDX_W-1:0] == IDX_LAST) begin
					pairs_d  = '0;
					cnt_d    = '0;
					state_d  = ST_IDLE;
					report_d = 1'b0;
					// The pass that follows reset reports nothing.
					if (report_q) begin
						done_d   = 1'b1;
						result_d = '{status: 1'b0, value: '0, pair_count: '0};
					end
				end
			end
			ST_IDLE: begin
				if (start) begin
					load_req = 1'b1;
					result_d = '{status: 1'b0, value: '0, pair_count: pairs_q};
					unique case (request.command)
						CMD_ADD: begin
							if (row_ok && col_ok) begin
								r_req.raddr = request.row_index;
								c_req.raddr = request.col_index;
								state_d     = ST_ADD_DROP;
							end else begin
								done_d          = 1'b1;
								result_d.status = 1'b1;
							end
						end
						CMD_COUNT: begin
							if (request.row_end >= {1'b0, request.row_index} &&
							    request.col_end >= {1'b0, request.col_index} &&
							    {1'b0, request.row_index} < stop_sel) begin
								r_req.raddr = request.row_index;
								cnt_d       = {1'b0, request.row_index} + 1'b1;
								stop_d      = stop_sel;
								acc_d       = '0;
								state_d     = ST_COUNT;
							end else begin
								done_d = 1'b1;
							end
						end
						CMD_TRANSPOSE: begin
							swap_d = ~swap_q;
							done_d = 1'b1;
						end
						CMD_CLEAR: begin
							cnt_d    = '0;
							report_d = 1'b1;
							state_d  = ST_CLEAR;
						end
						CMD_READ_ROW: begin
							if (row_ok) begin
								r_req.raddr = request.row_index;
								state_d     = ST_READ;
							end else begin
								done_d          = 1'b1;
								result_d.status = 1'b1;
							end
						end
						CMD_READ_COL: begin
							if (col_ok) begin
								c_req.raddr = request.col_index;
								state_d     = ST_READ;
							end else begin
								done_d          = 1'b1;
								result_d.status = 1'b1;
							end
						end
						default: begin
							done_d          = 1'b1;
							result_d.status = 1'b1;
						end
					endcase
				end
			end
			ST_ADD_DROP: begin
				// The maps always agree, so the old partner of the row points back at
				// the row and only its entry in the column map needs clearing.
				if (pr_valid) begin
					c_req.we    = 1'b1;
					c_req.waddr = rd_r[IDX_W-1:0];
					c_req.wdata = ENTRY_NONE;
				end
				if (pc_valid) begin
					r_req.we    = 1'b1;
					r_req.waddr = rd_c[IDX_W-1:0];
					r_req.wdata = ENTRY_NONE;
				end
				// When the pair already exists, both reads see the same pair.
				drops = {1'b0, pr_valid} +
					{1'b0, pc_valid && !(pr_valid && rd_r[IDX_W-1:0] == req_q.col_index)};
				pairs_d = pairs_q - SIDE_W'(drops);
				state_d = ST_ADD_SET;
			end
			ST_ADD_SET: begin
				r_req.we    = 1'b1;
				r_req.waddr = req_q.row_index;
				r_req.wdata = {1'b0, req_q.col_index};
				c_req.we    = 1'b1;
				c_req.waddr = req_q.col_index;
				c_req.wdata = {1'b0, req_q.row_index};
				pairs_d     = pairs_q + 1'b1;
				done_d      = 1'b1;
				result_d    = '{status: 1'b0, value: '0, pair_count: pairs_q + 1'b1};
				state_d     = ST_IDLE;
			end
			ST_COUNT: begin
				// Data of the row read in the previous cycle is checked here.
				hit = !rd_r[ENT_W-1] &&
					rd_r[IDX_W-1:0] >= req_q.col_index &&
					{1'b0, rd_r[IDX_W-1:0]} < req_q.col_end;
				acc_sum = acc_q + SIDE_W'(hit);
				if (cnt_q < stop_q) begin
					r_req.raddr = cnt_q[IDX_W-1:0];
					cnt_d       = cnt_q + 1'b1;
					acc_d       = acc_sum;
				end else begin
					done_d         = 1'b1;
					result_d.value = $signed({1'b0, acc_sum});
					state_d        = ST_IDLE;
				end
			end
			ST_READ: begin
				entry          = (req_q.command == CMD_READ_ROW) ? rd_r : rd_c;
				done_d         = 1'b1;
				result_d.value = $signed({entry[ENT_W-1], entry});
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			swap_q   <= 1'b0;
			report_q <= 1'b0;
			pairs_q  <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			swap_q   <= swap_d;
			report_q <= report_d;
			pairs_q  <= pairs_d;
			cnt_q    <= cnt_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			req_q <= request;
		end
		stop_q   <= stop_d;
		acc_q    <= acc_d;
		result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

/* hdl/one_to_one_assignment_table_core.sv */
// One-to-one row/column assignment table. A command is taken when start is high and
// busy is low; its result is shown for exactly one cycle with done high and cannot be
// held off. The count walk reads one row-map entry per cycle through the single read
// port of that memory, and an add reads both maps, then clears old partners, then
// writes the pair. After reset a clearing pass keeps busy high while both maps are
// swept; configuration writes are taken at any time, though only while no command is
// in flight do they take well-defined effect.
`timescale 1ns / 1ps
`default_nettype none

module one_to_one_assignment_table_core
	import ott_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire request_t             request,
	output logic                      busy,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIDE_W-1:0]    cfg_data
);

	sizes_t            sizes_q;
	logic [SIDE_W-1:0] cfg_sat;
	ram_req_t          ram_a, ram_b;
	logic [ENT_W-1:0]  rd_a, rd_b;

	// Sizes above the table side saturate.
	assign cfg_sat = (cfg_data > SIDE_MAX) ? SIDE_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q.rows <= SIDE_MAX;
			sizes_q.cols <= SIDE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_IN_USE: sizes_q.rows <= cfg_sat;
				REG_COLS_IN_USE: sizes_q.cols <= cfg_sat;
				default: ;
			endcase
		end
	end

	ott_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.sizes   (sizes_q),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.ram_a   (ram_a),
		.ram_b   (ram_b)
	);

	// Column of each original row.
	ott_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_SIDE)
	) u_row_to_col (
		.clk   (clk),
		.we    (ram_a.we),
		.waddr (ram_a.waddr),
		.wdata (ram_a.wdata),
		.raddr (ram_a.raddr),
		.rdata (rd_a)
	);

	// Row of each original column.
	ott_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_SIDE)
	) u_col_to_row (
		.clk   (clk),
		.we    (ram_b.we),
		.waddr (ram_b.waddr),
		.wdata (ram_b.wdata),
		.raddr (ram_b.raddr),
		.rdata (rd_b)
	);

endmodule

`default_nettype wire

/* hdl/ott_checker.sv */
// Port-level checks of the assignment table, bound to the top level.
// Uses ott_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "one_to_one_assignment_table_core_macros.svh"

module ott_checker
	import ott_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire request_t             request,
	input wire logic                 busy,
	input wire logic                 done,
	input wire result_t              result,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [SIDE_W-1:0]    cfg_data
);

	logic take;

	assign take = start && !busy;

	// A result is only shown once the block is free again.
	`OTT_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

	`OTT_ASSERT_NOW(a_pairs_bound, done, result.pair_count <= SIDE_MAX,
		"pair count beyond table side")

	`OTT_ASSERT_NEXT(a_transpose, take && request.command == CMD_TRANSPOSE,
		done && !result.status && result.value == '0, "transpose not reported next cycle")

	`OTT_ASSERT_NEXT(a_unknown, take && request.command > CMD_READ_COL,
		done && result.status && result.value == '0, "unknown command not rejected")

endmodule

bind one_to_one_assignment_table_core ott_checker u_checker (.*);

`default_nettype wire

/* bench/tb_one_to_one_assignment_table_core.sv */
// Self-checking testbench for one_to_one_assignment_table_core: directed edge cases, then
// random command streams over several table sizes, checked against an in-bench table model.
// Depends on ott_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_one_to_one_assignment_table_core;
	import ott_pkg::*;

	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 5_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	request_t             request = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIDE_W-1:0]    cfg_data = '0;
	logic                 busy;
	logic                 done;
	result_t              result;

	// Table model: column of each original row, row of each original column.
	logic [ENT_W-1:0]  col_of_row [MAX_SIDE];
	logic [ENT_W-1:0]  row_of_col [MAX_SIDE];
	logic [SIDE_W-1:0] pairs_now;
	logic [SIDE_W-1:0] rows_set;
	logic [SIDE_W-1:0] cols_set;
	bit                flipped;

	result_t pending_results [$];
	int      errors = 0;
	int      sent_total = 0;
	int      checked_total = 0;
	int      settings_used = 0;
	int      cycle_count = 0;
	bit      steady_send = 1'b0;

	one_to_one_assignment_table_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_one_to_one_assignment_table_core: done, errors");
			$finish;
		end
	end

	// Map 0 is indexed by original rows, map 1 by original columns.
	function automatic logic [ENT_W-1:0] map_rd(bit sel, int idx);
		return sel ? row_of_col[idx] : col_of_row[idx];
	endfunction

	function automatic void map_wr(bit sel, int idx, logic [ENT_W-1:0] v);
		if (sel)
			row_of_col[idx] = v;
		else
			col_of_row[idx] = v;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < MAX_SIDE; i++) begin
			col_of_row[i] = ENTRY_NONE;
			row_of_col[i] = ENTRY_NONE;
		end
		pairs_now = '0;
	endfunction

	// Removes the pair that holds idx in map fwd, and its back entry if it still points here.
	function automatic void drop_partner(bit fwd, int idx);
		logic [ENT_W-1:0] p;
		p = map_rd(fwd, idx);
		if (p >= MAX_SIDE)
			return;
		map_wr(fwd, idx, ENTRY_NONE);
		if (map_rd(!fwd, p) == idx)
			map_wr(!fwd, p, ENTRY_NONE);
		if (pairs_now > 0)
			pairs_now--;
	endfunction

	function automatic logic [SIDE_W-1:0] saturate_side(logic [SIDE_W-1:0] v);
		return (v > MAX_SIDE) ? SIDE_MAX : v;
	endfunction

	// Applies one command to the table model and returns the result it must produce.
	function automatic result_t apply_to_table(request_t req);
		result_t           res;
		logic [SIDE_W-1:0] nr;
		logic [SIDE_W-1:0] nc;
		logic [SIDE_W-1:0] stop;
		logic [ENT_W-1:0]  c;
		bit                rsel;
		int                tally;
		res = '0;
		tally = 0;
		nr = flipped ? cols_set : rows_set;
		nc = flipped ? rows_set : cols_set;
		rsel = flipped;
		case (req.command)
			CMD_ADD: begin
				if (req.row_index < nr && req.col_index < nc) begin
					drop_partner(rsel, req.row_index);
					drop_partner(!rsel, req.col_index);
					map_wr(rsel, req.row_index, ENT_W'(req.col_index));
					map_wr(!rsel, req.col_index, ENT_W'(req.row_index));
					pairs_now++;
				end else begin
					res.status = 1'b1;
				end
			end
			CMD_COUNT: begin
				if (req.row_end >= req.row_index && req.col_end >= req.col_index) begin
					stop = (req.row_end < nr) ? req.row_end : nr;
					for (int i = req.row_index; i < stop; i++) begin
						c = map_rd(rsel, i);
						if (c != ENTRY_NONE && c >= req.col_index && c < req.col_end)
							tally++;
					end
				end
				res.value = VAL_W'(tally);
			end
			CMD_TRANSPOSE: flipped = !flipped;
			CMD_CLEAR: wipe_table();
			CMD_READ_ROW: begin
				if (req.row_index < nr)
					res.value = $signed(map_rd(rsel, req.row_index));
				else
					res.status = 1'b1;
			end
			CMD_READ_COL: begin
				if (req.col_index < nc)
					res.value = $signed(map_rd(!rsel, req.col_index));
				else
					res.status = 1'b1;
			end
			default: res.status = 1'b1;
		endcase
		res.pair_count = pairs_now;
		return res;
	endfunction

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with no command outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked_total++;
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (result.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, result.value);
					errors++;
				end
				if (result.pair_count !== want.pair_count) begin
					$error("pair_count: expected %0d, got %0d", want.pair_count,
						result.pair_count);
					errors++;
				end
			end
		end
	end

	function automatic request_t make_req(logic [2:0] cmd, int row, int col, int rend,
		int cend);
		request_t req;
		req.command = cmd;
		req.row_index = IDX_W'(row);
		req.col_index = IDX_W'(col);
		req.row_end = SIDE_W'(rend);
		req.col_end = SIDE_W'(cend);
		return req;
	endfunction

	// Start stays high from one transfer to the next unless a gap is inserted.
	task automatic issue_command(request_t req);
		if (!steady_send && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 30);
		end
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(apply_to_table(req));
		sent_total++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_sizes(logic [SIDE_W-1:0] rows, logic [SIDE_W-1:0] cols);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_IN_USE;
		cfg_data <= rows;
		@(posedge clk);
		cfg_index <= REG_COLS_IN_USE;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_set = saturate_side(rows);
		cols_set = saturate_side(cols);
		settings_used++;
	endtask

	// Mostly in range, a window near zero for collisions, some just past the size.
	function automatic logic [IDX_W-1:0] pick_index(int n);
		int r;
		int pick;
		r = $urandom_range(0, 99);
		if (r < 8)
			pick = $urandom_range(0, MAX_SIDE - 1);
		else if (r < 18)
			pick = n + $urandom_range(0, 2);
		else if (r < 58)
			pick = $urandom_range(0, ((n < 16) ? n : 16) - 1);
		else
			pick = $urandom_range(0, n - 1);
		if (pick > MAX_SIDE - 1)
			pick = MAX_SIDE - 1;
		return IDX_W'(pick);
	endfunction

	function automatic logic [SIDE_W-1:0] pick_end(int first);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return SIDE_W'($urandom_range(0, 2047));
		if (r < 13)
			return SIDE_MAX;
		if (r < 18)
			return SIDE_W'((first == 0) ? 0 : first - 1);
		return SIDE_W'(first + $urandom_range(0, 12));
	endfunction

	task automatic random_burst(int count);
		request_t    req;
		logic [63:0] noise;
		int          k;
		int          nr;
		int          nc;
		repeat (count) begin
			nr = flipped ? cols_set : rows_set;
			nc = flipped ? rows_set : cols_set;
			k = $urandom_range(0, 99);
			req.row_index = pick_index(nr);
			req.col_index = pick_index(nc);
			req.row_end = SIDE_W'($urandom_range(0, 2047));
			req.col_end = SIDE_W'($urandom_range(0, 2047));
			if (k < 45) begin
				req.command = CMD_ADD;
			end else if (k < 60) begin
				req.command = CMD_COUNT;
				req.row_end = pick_end(req.row_index);
				req.col_end = pick_end(req.col_index);
			end else if (k < 64) begin
				req.command = CMD_TRANSPOSE;
			end else if (k < 66) begin
				req.command = CMD_CLEAR;
			end else if (k < 80) begin
				req.command = CMD_READ_ROW;
			end else if (k < 94) begin
				req.command = CMD_READ_COL;
			end else if (k < 97) begin
				req.command = (k % 2) ? CMD_UNUSED_7 : CMD_UNUSED_6;
			end else begin
				noise = {$urandom, $urandom};
				req = noise[$bits(request_t)-1:0];
			end
			issue_command(req);
		end
	endtask

	task automatic test_directed_edges();
		issue_command(make_req(CMD_ADD, 0, 0, 0, 0));
		issue_command(make_req(CMD_ADD, IDX_LAST, IDX_LAST, '1, '1));
		// This add takes row 0 and column 1023 away from two different pairs.
		issue_command(make_req(CMD_ADD, 0, IDX_LAST, 0, 0));
		issue_command(make_req(CMD_ADD, 0, IDX_LAST, 0, 0));
		issue_command(make_req(CMD_READ_ROW, 0, 0, 0, 0));
		issue_command(make_req(CMD_READ_COL, 0, IDX_LAST, 0, 0));
		issue_command(make_req(CMD_ADD, 5, 7, 0, 0));
		issue_command(make_req(CMD_COUNT, 0, 0, SIDE_MAX, SIDE_MAX));
		issue_command(make_req(CMD_COUNT, 10, 0, 3, SIDE_MAX));
		issue_command(make_req(CMD_COUNT, 0, 8, SIDE_MAX, 2));
		issue_command(make_req(CMD_COUNT, 4, 6, '1, 8));
		issue_command(make_req(CMD_TRANSPOSE, 0, 0, 0, 0));
		issue_command(make_req(CMD_READ_ROW, 7, 0, 0, 0));
		issue_command(make_req(CMD_ADD, 1, 2, 0, 0));
		issue_command(make_req(CMD_TRANSPOSE, 0, 0, 0, 0));
		issue_command(make_req(CMD_READ_COL, 0, 1, 0, 0));
		issue_command(make_req(CMD_UNUSED_6, 0, 0, 0, 0));
		issue_command(make_req(CMD_UNUSED_7, IDX_LAST, IDX_LAST, '1, '1));
		issue_command(make_req(CMD_CLEAR, 0, 0, 0, 0));
		issue_command(make_req(CMD_READ_COL, 0, IDX_LAST, 0, 0));
	endtask

	// Pairs stored beyond a shrunken size must survive and reappear when it grows back.
	task automatic test_shrink_and_range();
		issue_command(make_req(CMD_ADD, 900, 900, 0, 0));
		write_sizes(SIDE_W'(1), SIDE_W'(1));
		issue_command(make_req(CMD_ADD, 1, 0, 0, 0));
		issue_command(make_req(CMD_ADD, 0, 5, 0, 0));
		issue_command(make_req(CMD_ADD, 0, 0, 0, 0));
		issue_command(make_req(CMD_READ_ROW, 900, 0, 0, 0));
		issue_command(make_req(CMD_READ_COL, 0, 1, 0, 0));
		issue_command(make_req(CMD_COUNT, 0, 0, SIDE_MAX, SIDE_MAX));
		write_sizes('1, '1);
		issue_command(make_req(CMD_READ_ROW, 900, 0, 0, 0));
	endtask

	task automatic test_dense_table();
		write_sizes(SIDE_W'(8), SIDE_W'(8));
		random_burst(220);
	endtask

	task automatic test_steady_full();
		write_sizes(SIDE_MAX, SIDE_MAX);
		steady_send = 1'b1;
		random_burst(150);
		steady_send = 1'b0;
	endtask

	task automatic test_uneven_sizes();
		write_sizes(SIDE_W'(37), SIDE_W'(100));
		random_burst(150);
		write_sizes(SIDE_W'(300), SIDE_W'(5));
		random_burst(180);
	endtask

	task automatic test_thin_tables();
		write_sizes(SIDE_W'(1), SIDE_MAX);
		random_burst(50);
		write_sizes('1, SIDE_W'(1));
		random_burst(50);
	endtask

	initial begin
		rows_set = SIDE_MAX;
		cols_set = SIDE_MAX;
		flipped = 1'b0;
		wipe_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// The core sweeps both maps after reset before it takes commands.
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);

		test_directed_edges();
		test_shrink_and_range();
		test_dense_table();
		test_steady_full();
		test_uneven_sizes();
		test_thin_tables();

		wait_idle();
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("Ran %0d commands over %0d size settings; %0d results compared.",
			sent_total, settings_used, checked_total);
		if (errors == 0)
			$display("tb_one_to_one_assignment_table_core: done, clean");
		else
			$display("tb_one_to_one_assignment_table_core: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/ott_pkg.sv
hdl/ott_ram.sv
hdl/ott_ctrl.sv
hdl/one_to_one_assignment_table_core.sv
hdl/ott_checker.sv
bench/tb_one_to_one_assignment_table_core.sv
